>>> src/cpec_pkg.sv
// Package for the circle pair elastic collision unit: fixed point constants,
// stage map, word and pipeline types, and the shared step functions.
// No dependencies.
package cpec_pkg;

    // Fixed point format and register reset values
    localparam int FRAC_BITS = 16;
    localparam logic [31:0] THRESH_RESET = 32'(((64'd1 << FRAC_BITS) + 64'd5) / 64'd10);
    localparam logic [31:0] GAIN_RESET   = 32'(64'd10 << FRAC_BITS);

    // Width of the scaled push magnitude after dropping the fraction bits
    localparam int PUSH_W = 64 - FRAC_BITS;

    // One root bit per sqrt stage; the mass exchange quotient (34 bits) rides along
    localparam int SQRT_STEPS = 34;
    localparam int AXIS_Q_W   = 32;

    // Stage map
    localparam int ST_IN      = 0;
    localparam int ST_MUL     = 1;
    localparam int ST_SUM     = 2;
    localparam int ST_ROOT0   = 3;
    localparam int ST_CMP     = ST_ROOT0 + SQRT_STEPS;
    localparam int ST_AMUL    = ST_CMP + 1;
    localparam int ST_DIV0    = ST_AMUL + 1;
    localparam int ST_GAIN    = ST_DIV0 + AXIS_Q_W;
    localparam int ST_OUT     = ST_GAIN + 1;
    localparam int NUM_STAGES = ST_OUT + 1;

    typedef enum logic [0:0] {
        REG_THRESH = 1'b0,
        REG_GAIN   = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic [31:0]        mass_a;
        logic [31:0]        mass_b;
        logic [30:0]        radius_a;
        logic [30:0]        radius_b;
        logic signed [31:0] pos_x_a;
        logic signed [31:0] pos_y_a;
        logic signed [31:0] pos_x_b;
        logic signed [31:0] pos_y_b;
        logic signed [31:0] vel_x_a;
        logic signed [31:0] vel_y_a;
        logic signed [31:0] vel_x_b;
        logic signed [31:0] vel_y_b;
    } in_t;

    typedef struct packed {
        logic signed [31:0] new_pos_x_a;
        logic signed [31:0] new_pos_y_a;
        logic signed [31:0] new_pos_x_b;
        logic signed [31:0] new_pos_y_b;
        logic signed [31:0] new_vel_x_a;
        logic signed [31:0] new_vel_y_a;
        logic signed [31:0] new_vel_x_b;
        logic signed [31:0] new_vel_y_b;
        logic signed [31:0] push_x;
        logic signed [31:0] push_y;
        logic               pushed;
        logic               touching;
    } res_t;

    // Everything one pair carries down the pipe. Exchange slots:
    // 0 = x of a, 1 = x of b, 2 = y of a, 3 = y of b.
    typedef struct packed {
        logic [31:0]             ma;
        logic [31:0]             mb;
        logic [30:0]             ra;
        logic [30:0]             rb;
        logic signed [31:0]      pxa;
        logic signed [31:0]      pya;
        logic signed [31:0]      pxb;
        logic signed [31:0]      pyb;
        logic signed [31:0]      vxa;
        logic signed [31:0]      vya;
        logic signed [31:0]      vxb;
        logic signed [31:0]      vyb;
        logic                    dx_neg;
        logic                    dy_neg;
        logic [32:0]             ax;
        logic [32:0]             ay;
        logic [64:0]             sqx;
        logic [64:0]             sqy;
        logic [67:0]             sq_bits;
        logic [35:0]             sq_rem;
        logic [33:0]             root;
        logic                    ex_x_neg;
        logic                    ex_y_neg;
        logic [32:0]             ex_x_mag;
        logic [32:0]             ex_y_mag;
        logic                    tot_zero;
        logic [32:0]             tot;
        logic [3:0][32:0]        ex_rem;
        logic [3:0][33:0]        ex_qn;
        logic                    touching;
        logic                    pushed;
        logic [31:0]             ov;
        logic [1:0][33:0]        ax_rem;
        logic [1:0][31:0]        ax_qn;
        logic [1:0][63:0]        pp;
        logic [1:0][31:0]        push;
    } pipe_t;

    typedef struct packed {
        logic [35:0] rem;
        logic [33:0] root;
    } sqrt_t;

    typedef struct packed {
        logic [33:0] rem;
        logic        q;
    } div_t;

    // One bit of the integer square root: bring down a pair, try 4r+1
    function automatic sqrt_t sqrt_step(input logic [35:0] rem, input logic [33:0] root,
                                        input logic [1:0] pair);
        logic [37:0] r4;
        logic [37:0] trial;
        sqrt_t       o;
        r4    = {rem, pair};
        trial = {2'b00, root, 2'b01};
        if (r4 >= trial)
        begin
            o.rem  = 36'(r4 - trial);
            o.root = {root[32:0], 1'b1};
        end
        else
        begin
            o.rem  = r4[35:0];
            o.root = {root[32:0], 1'b0};
        end
        return o;
    endfunction

    // One bit of restoring division: bring down a bit, subtract if it fits
    function automatic div_t div_step(input logic [33:0] rem, input logic bin,
                                      input logic [33:0] d);
        logic [34:0] r2;
        div_t        o;
        r2 = {rem, bin};
        if (r2 >= {1'b0, d})
        begin
            o.rem = 34'(r2 - {1'b0, d});
            o.q   = 1'b1;
        end
        else
        begin
            o.rem = r2[33:0];
            o.q   = 1'b0;
        end
        return o;
    endfunction

    // Clamp a wide signed value to 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
        logic signed [31:0] o;
        if (v > 36'sh07FFFFFFF)
            o = 32'sh7FFFFFFF;
        else if (v < 36'shF80000000)
            o = 32'sh80000000;
        else
            o = v[31:0];
        return o;
    endfunction

endpackage

>>> src/cpec_core.sv
// Collision datapath: a fixed-length pipeline with a common advance enable.
// Depends on cpec_pkg (types, stage map, step functions).
module cpec_core (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_valid,
    input  cpec_pkg::in_t   in_word,
    input  logic [31:0]     thresh,
    input  logic [31:0]     gain,
    output logic            res_valid,
    output cpec_pkg::res_t  res_word
);

    localparam int NS = cpec_pkg::NUM_STAGES;

    cpec_pkg::pipe_t stage_reg  [NS];
    cpec_pkg::pipe_t stage_next [NS];
    logic [NS-1:0]   valid_reg;

    // Offsets, magnitudes and total mass
    always_comb
    begin
        logic signed [32:0] dx;
        logic signed [32:0] dy;
        logic signed [32:0] ex;
        logic signed [32:0] ey;
        cpec_pkg::pipe_t    s;
        s        = '0;
        s.ma     = in_word.mass_a;
        s.mb     = in_word.mass_b;
        s.ra     = in_word.radius_a;
        s.rb     = in_word.radius_b;
        s.pxa    = in_word.pos_x_a;
        s.pya    = in_word.pos_y_a;
        s.pxb    = in_word.pos_x_b;
        s.pyb    = in_word.pos_y_b;
        s.vxa    = in_word.vel_x_a;
        s.vya    = in_word.vel_y_a;
        s.vxb    = in_word.vel_x_b;
        s.vyb    = in_word.vel_y_b;
        dx       = {in_word.pos_x_a[31], in_word.pos_x_a} - {in_word.pos_x_b[31], in_word.pos_x_b};
        dy       = {in_word.pos_y_a[31], in_word.pos_y_a} - {in_word.pos_y_b[31], in_word.pos_y_b};
        ex       = {in_word.vel_x_b[31], in_word.vel_x_b} - {in_word.vel_x_a[31], in_word.vel_x_a};
        ey       = {in_word.vel_y_b[31], in_word.vel_y_b} - {in_word.vel_y_a[31], in_word.vel_y_a};
        s.dx_neg = dx[32];
        s.dy_neg = dy[32];
        s.ax     = dx[32] ? 33'(-dx) : 33'(dx);
        s.ay     = dy[32] ? 33'(-dy) : 33'(dy);
        s.ex_x_neg = ex[32];
        s.ex_y_neg = ey[32];
        s.ex_x_mag = ex[32] ? 33'(-ex) : 33'(ex);
        s.ex_y_mag = ey[32] ? 33'(-ey) : 33'(ey);
        s.tot      = {1'b0, in_word.mass_a} + {1'b0, in_word.mass_b};
        s.tot_zero = (s.tot == 33'd0);
        stage_next[cpec_pkg::ST_IN] = s;
    end

    // Squares of the offsets and doubled mass products of the exchange
    always_comb
    begin
        logic [65:0]     sq;
        logic [64:0]     prod;
        logic [64:0]     p2;
        cpec_pkg::pipe_t s;
        s     = stage_reg[cpec_pkg::ST_MUL - 1];
        sq    = s.ax * s.ax;
        s.sqx = sq[64:0];
        sq    = s.ay * s.ay;
        s.sqy = sq[64:0];
        for (int k = 0; k < 4; k++)
        begin
            prod = ((k % 2) == 0 ? s.mb : s.ma) * (k < 2 ? s.ex_x_mag : s.ex_y_mag);
            p2   = {prod[63:0], 1'b0};
            s.ex_rem[k] = {2'b00, p2[64:34]};
            s.ex_qn[k]  = p2[33:0];
        end
        stage_next[cpec_pkg::ST_MUL] = s;
    end

    // Sum of squares, seed the root
    always_comb
    begin
        logic [65:0]     sum;
        cpec_pkg::pipe_t s;
        s         = stage_reg[cpec_pkg::ST_SUM - 1];
        sum       = {1'b0, s.sqx} + {1'b0, s.sqy};
        s.sq_bits = {2'b00, sum};
        s.sq_rem  = '0;
        s.root    = '0;
        stage_next[cpec_pkg::ST_SUM] = s;
    end

    // One root bit and one exchange quotient bit per stage
    for (genvar j = 0; j < cpec_pkg::SQRT_STEPS; j++)
    begin : g_root
        always_comb
        begin
            cpec_pkg::sqrt_t sr;
            cpec_pkg::div_t  dr;
            cpec_pkg::pipe_t s;
            s         = stage_reg[cpec_pkg::ST_ROOT0 + j - 1];
            sr        = cpec_pkg::sqrt_step(s.sq_rem, s.root, s.sq_bits[67:66]);
            s.sq_rem  = sr.rem;
            s.root    = sr.root;
            s.sq_bits = {s.sq_bits[65:0], 2'b00};
            for (int k = 0; k < 4; k++)
            begin
                dr = cpec_pkg::div_step({1'b0, s.ex_rem[k]}, s.ex_qn[k][33], {1'b0, s.tot});
                s.ex_rem[k] = dr.rem[32:0];
                s.ex_qn[k]  = {s.ex_qn[k][32:0], dr.q};
            end
            stage_next[cpec_pkg::ST_ROOT0 + j] = s;
        end
    end

    // Overlap test and velocity updates
    always_comb
    begin
        logic [31:0]        rsum;
        logic [34:0]        ovs;
        logic signed [35:0] na;
        logic signed [35:0] nb;
        logic signed [35:0] ma_;
        logic signed [35:0] mb_;
        cpec_pkg::pipe_t    s;
        s          = stage_reg[cpec_pkg::ST_CMP - 1];
        rsum       = {1'b0, s.ra} + {1'b0, s.rb};
        ovs        = {3'b000, rsum} - {1'b0, s.root};
        s.touching = ({2'b00, rsum} >= s.root);
        s.pushed   = (s.root != 34'd0) && !ovs[34] && (ovs[33:0] > {2'b00, thresh});
        s.ov       = ovs[31:0];
        // x axis
        ma_ = {2'b00, s.ex_qn[0]};
        mb_ = {2'b00, s.ex_qn[1]};
        na  = s.ex_x_neg ? 36'(s.vxa) - ma_ : 36'(s.vxa) + ma_;
        nb  = s.ex_x_neg ? 36'(s.vxb) + mb_ : 36'(s.vxb) - mb_;
        if (!s.tot_zero)
        begin
            s.vxa = cpec_pkg::sat32(na);
            s.vxb = cpec_pkg::sat32(nb);
        end
        // y axis
        ma_ = {2'b00, s.ex_qn[2]};
        mb_ = {2'b00, s.ex_qn[3]};
        na  = s.ex_y_neg ? 36'(s.vya) - ma_ : 36'(s.vya) + ma_;
        nb  = s.ex_y_neg ? 36'(s.vyb) + mb_ : 36'(s.vyb) - mb_;
        if (!s.tot_zero)
        begin
            s.vya = cpec_pkg::sat32(na);
            s.vyb = cpec_pkg::sat32(nb);
        end
        stage_next[cpec_pkg::ST_CMP] = s;
    end

    // Overlap times axis offset, split into the divider seed
    always_comb
    begin
        logic [64:0]     p;
        cpec_pkg::pipe_t s;
        s           = stage_reg[cpec_pkg::ST_AMUL - 1];
        p           = s.ov * s.ax;
        s.ax_rem[0] = {2'b00, p[63:32]};
        s.ax_qn[0]  = p[31:0];
        p           = s.ov * s.ay;
        s.ax_rem[1] = {2'b00, p[63:32]};
        s.ax_qn[1]  = p[31:0];
        stage_next[cpec_pkg::ST_AMUL] = s;
    end

    // Divide by the distance, one quotient bit per stage
    for (genvar j = 0; j < cpec_pkg::AXIS_Q_W; j++)
    begin : g_div
        always_comb
        begin
            cpec_pkg::div_t  dr;
            cpec_pkg::pipe_t s;
            s = stage_reg[cpec_pkg::ST_DIV0 + j - 1];
            for (int a = 0; a < 2; a++)
            begin
                dr          = cpec_pkg::div_step(s.ax_rem[a], s.ax_qn[a][31], s.root);
                s.ax_rem[a] = dr.rem;
                s.ax_qn[a]  = {s.ax_qn[a][30:0], dr.q};
            end
            stage_next[cpec_pkg::ST_DIV0 + j] = s;
        end
    end

    // Scale the unit-line terms by the gain
    always_comb
    begin
        cpec_pkg::pipe_t s;
        s = stage_reg[cpec_pkg::ST_GAIN - 1];
        for (int a = 0; a < 2; a++)
            s.pp[a] = s.ax_qn[a] * gain;
        stage_next[cpec_pkg::ST_GAIN] = s;
    end

    // Apply shifts, clamp the push
    always_comb
    begin
        logic [cpec_pkg::PUSH_W-1:0] pm;
        logic                        big;
        logic                        neg;
        logic [30:0]                 sh;
        logic signed [35:0]          shs;
        logic signed [35:0]          pa;
        logic signed [35:0]          pb;
        cpec_pkg::pipe_t             s;
        s = stage_reg[cpec_pkg::ST_OUT - 1];
        for (int a = 0; a < 2; a++)
        begin
            pm  = s.pp[a][63:cpec_pkg::FRAC_BITS];
            big = |pm[cpec_pkg::PUSH_W-1:31];
            neg = (a == 0) ? s.dx_neg : s.dy_neg;
            sh  = s.pushed ? s.ax_qn[a][31:1] : 31'd0;
            shs = neg ? -{5'b00000, sh} : {5'b00000, sh};
            if (!s.pushed)
                s.push[a] = '0;
            else if (big)
                s.push[a] = neg ? 32'h80000000 : 32'h7FFFFFFF;
            else
                s.push[a] = neg ? 32'(-{1'b0, pm[30:0]}) : {1'b0, pm[30:0]};
            pa = (a == 0) ? 36'(s.pxa) : 36'(s.pya);
            pb = (a == 0) ? 36'(s.pxb) : 36'(s.pyb);
            if (a == 0)
            begin
                s.pxa = cpec_pkg::sat32(pa + shs);
                s.pxb = cpec_pkg::sat32(pb - shs);
            end
            else
            begin
                s.pya = cpec_pkg::sat32(pa + shs);
                s.pyb = cpec_pkg::sat32(pb - shs);
            end
        end
        stage_next[cpec_pkg::ST_OUT] = s;
    end

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (en)
            valid_reg <= {valid_reg[NS-2:0], in_valid};
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < NS; k++)
                stage_reg[k] <= stage_next[k];
        end
    end

    // Map the last stage onto the result word
    assign res_valid            = valid_reg[NS-1];
    assign res_word.new_pos_x_a = stage_reg[NS-1].pxa;
    assign res_word.new_pos_y_a = stage_reg[NS-1].pya;
    assign res_word.new_pos_x_b = stage_reg[NS-1].pxb;
    assign res_word.new_pos_y_b = stage_reg[NS-1].pyb;
    assign res_word.new_vel_x_a = stage_reg[NS-1].vxa;
    assign res_word.new_vel_y_a = stage_reg[NS-1].vya;
    assign res_word.new_vel_x_b = stage_reg[NS-1].vxb;
    assign res_word.new_vel_y_b = stage_reg[NS-1].vyb;
    assign res_word.push_x      = stage_reg[NS-1].push[0];
    assign res_word.push_y      = stage_reg[NS-1].push[1];
    assign res_word.pushed      = stage_reg[NS-1].pushed;
    assign res_word.touching    = stage_reg[NS-1].touching;

endmodule

>>> src/circle_pair_elastic_collision_unit.sv
// Top level of the circle pair elastic collision unit: ports, config
// registers, output register and skid. Depends on cpec_pkg and cpec_core.
//
//   channel | direction | handshake             | word
//   in      | input     | in_valid / in_ready   | two bodies: mass, radius, pos, vel
//   out     | output    | out_valid / out_ready | new pos, new vel, push, flags
//   cfg     | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One pair per cycle sustained while the skid is empty; from accept to out_valid a pair
// passes the 73 pipeline stages, which include the 34-stage square root and the
// 32-stage distance divider, and then the output register.
// Reset clears valid bits and loads the register defaults; cfg_ready is always high.
// A stalled output fills the skid; only then does in_ready drop and the pipe freeze.
module circle_pair_elastic_collision_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [31:0]        mass_a,
    input  logic [31:0]        mass_b,
    input  logic [30:0]        radius_a,
    input  logic [30:0]        radius_b,
    input  logic signed [31:0] pos_x_a,
    input  logic signed [31:0] pos_y_a,
    input  logic signed [31:0] pos_x_b,
    input  logic signed [31:0] pos_y_b,
    input  logic signed [31:0] vel_x_a,
    input  logic signed [31:0] vel_y_a,
    input  logic signed [31:0] vel_x_b,
    input  logic signed [31:0] vel_y_b,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] new_pos_x_a,
    output logic signed [31:0] new_pos_y_a,
    output logic signed [31:0] new_pos_x_b,
    output logic signed [31:0] new_pos_y_b,
    output logic signed [31:0] new_vel_x_a,
    output logic signed [31:0] new_vel_y_a,
    output logic signed [31:0] new_vel_x_b,
    output logic signed [31:0] new_vel_y_b,
    output logic signed [31:0] push_x,
    output logic signed [31:0] push_y,
    output logic               pushed,
    output logic               touching,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [0:0]         cfg_index,
    input  logic [31:0]        cfg_data
);

    logic [31:0]    thresh_reg;
    logic [31:0]    gain_reg;
    cpec_pkg::in_t  in_word;
    cpec_pkg::res_t core_res;
    logic           core_valid;
    logic           en;
    cpec_pkg::res_t out_reg;
    cpec_pkg::res_t out_next;
    logic           out_valid_reg;
    logic           out_valid_next;
    cpec_pkg::res_t skid_reg;
    cpec_pkg::res_t skid_next;
    logic           skid_valid_reg;
    logic           skid_valid_next;
    logic           take;

    // Config registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_reg <= cpec_pkg::THRESH_RESET;
            gain_reg   <= cpec_pkg::GAIN_RESET;
        end
        else if (cfg_valid)
        begin
            case (cpec_pkg::reg_idx_t'(cfg_index))
                cpec_pkg::REG_THRESH: thresh_reg <= cfg_data;
                cpec_pkg::REG_GAIN:   gain_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // Gather the input word
    assign in_word.mass_a   = mass_a;
    assign in_word.mass_b   = mass_b;
    assign in_word.radius_a = radius_a;
    assign in_word.radius_b = radius_b;
    assign in_word.pos_x_a  = pos_x_a;
    assign in_word.pos_y_a  = pos_y_a;
    assign in_word.pos_x_b  = pos_x_b;
    assign in_word.pos_y_b  = pos_y_b;
    assign in_word.vel_x_a  = vel_x_a;
    assign in_word.vel_y_a  = vel_y_a;
    assign in_word.vel_x_b  = vel_x_b;
    assign in_word.vel_y_b  = vel_y_b;

    // Pipe advances while the skid is empty
    assign en       = !skid_valid_reg;
    assign in_ready = en;

    cpec_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (in_valid),
        .in_word   (in_word),
        .thresh    (thresh_reg),
        .gain      (gain_reg),
        .res_valid (core_valid),
        .res_word  (core_res)
    );

    // Output register and skid: drain skid first, park a word when stalled
    always_comb
    begin
        take            = out_valid_reg && out_ready;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        skid_next       = skid_reg;
        skid_valid_next = skid_valid_reg;
        if (skid_valid_reg)
        begin
            if (take)
            begin
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (core_valid)
        begin
            if (!out_valid_reg || take)
            begin
                out_next       = core_res;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = core_res;
                skid_valid_next = 1'b1;
            end
        end
        else if (take)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    // Drive the result ports
    assign out_valid   = out_valid_reg;
    assign new_pos_x_a = out_reg.new_pos_x_a;
    assign new_pos_y_a = out_reg.new_pos_y_a;
    assign new_pos_x_b = out_reg.new_pos_x_b;
    assign new_pos_y_b = out_reg.new_pos_y_b;
    assign new_vel_x_a = out_reg.new_vel_x_a;
    assign new_vel_y_a = out_reg.new_vel_y_a;
    assign new_vel_x_b = out_reg.new_vel_x_b;
    assign new_vel_y_b = out_reg.new_vel_y_b;
    assign push_x      = out_reg.push_x;
    assign push_y      = out_reg.push_y;
    assign pushed      = out_reg.pushed;
    assign touching    = out_reg.touching;

endmodule

>>> src/cpec_checker.sv
// Port-level checks for the circle pair elastic collision unit, bound to
// the top level. Depends on circle_pair_elastic_collision_unit.
module cpec_port_props (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic signed [31:0] push_x,
    input logic signed [31:0] push_y,
    input logic               pushed,
    input logic               touching,
    input logic               cfg_ready
);

    // Keep out_valid high while a result word is stalled
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result word dropped while stalled");

    // Drop in_ready only after a stalled output
    a_ready_drop: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(in_ready) |-> $past(out_valid && !out_ready))
        else $error("in_ready fell without an output stall");

    // A push needs contact
    a_push_touch: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && pushed |-> touching)
        else $error("pushed without touching");

    // No push force without a push
    a_push_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !pushed |-> (push_x == 32'sd0) && (push_y == 32'sd0))
        else $error("push force set while not pushed");

    // Config port never stalls
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("cfg_ready low");

endmodule

bind circle_pair_elastic_collision_unit cpec_port_props u_cpec_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .push_x    (push_x),
    .push_y    (push_y),
    .pushed    (pushed),
    .touching  (touching),
    .cfg_ready (cfg_ready)
);

>>> tb/sv/cpec_checker.sv
`timescale 1ns / 100ps
// Checker for the circle pair elastic collision unit: watches the input, output
// and register write channels, predicts every result word and compares it.
// Depends on cpec_pkg for the word types and register indexes.
module cpec_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  cpec_pkg::in_t      in_word,
    input  logic               out_valid,
    input  logic               out_ready,
    input  cpec_pkg::res_t     out_word,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [0:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    output int                 fail_count,
    output int                 pending
);
    import cpec_pkg::*;

    logic [31:0] thresh_q;
    logic [31:0] gain_q;
    res_t        collision_q[$];

    // Clamp a wide signed value into the 32-bit range
    function automatic logic signed [31:0] clamp32(input longint v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647)
            r = 32'sh7FFFFFFF;
        else if (v < -64'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

    // Shift and push along one axis of the centre line
    function automatic void axis_pull(input longint ovl, input longint d,
                                      input logic [127:0] cdist, input logic [31:0] gain,
                                      output longint shift, output logic signed [31:0] push);
        logic [127:0] mag;
        logic [127:0] q;
        logic [127:0] p;
        mag = (d < 0) ? 128'(-d) : 128'(d);
        q = (128'(ovl) * mag) / cdist;
        p = q * {96'b0, gain};
        if (p > {64'b0, 64'hFFFF_FFFF_FFFF_FFFF})
            p = {64'b0, 64'hFFFF_FFFF_FFFF_FFFF};
        p = p >> FRAC_BITS;
        if (p > (128'd1 << 32))
            p = 128'd1 << 32;
        if (d < 0)
        begin
            shift = -longint'(q >> 1);
            push  = clamp32(-longint'(p));
        end
        else
        begin
            shift = longint'(q >> 1);
            push  = clamp32(longint'(p));
        end
    endfunction

    // One-dimensional elastic exchange of velocities
    function automatic void swap_momentum(input logic [31:0] ma, input logic [31:0] mb,
                                          input longint va, input longint vb,
                                          output logic signed [31:0] na,
                                          output logic signed [31:0] nb);
        logic [127:0] tot;
        logic [127:0] mag;
        longint       e;
        longint       ca;
        longint       cb;
        tot = {96'b0, ma} + {96'b0, mb};
        e   = vb - va;
        mag = (e < 0) ? 128'(-e) : 128'(e);
        if (tot == 0)
        begin
            na = clamp32(va);
            nb = clamp32(vb);
        end
        else
        begin
            ca = longint'((128'd2 * {96'b0, mb} * mag) / tot);
            cb = longint'((128'd2 * {96'b0, ma} * mag) / tot);
            if (e < 0)
            begin
                na = clamp32(va - ca);
                nb = clamp32(vb + cb);
            end
            else
            begin
                na = clamp32(va + ca);
                nb = clamp32(vb - cb);
            end
        end
    endfunction

    // Resolve one pair of bodies
    function automatic res_t resolve_pair(input in_t w, input logic [31:0] thr,
                                          input logic [31:0] gain);
        res_t         r;
        longint       dx;
        longint       dy;
        longint       rsum;
        longint       ovl;
        longint       shx;
        longint       shy;
        logic [127:0] sum;
        logic [127:0] rem;
        logic [127:0] root;
        logic [127:0] trial;
        dx   = longint'(w.pos_x_a) - longint'(w.pos_x_b);
        dy   = longint'(w.pos_y_a) - longint'(w.pos_y_b);
        sum  = 128'(dx < 0 ? -dx : dx) * 128'(dx < 0 ? -dx : dx)
             + 128'(dy < 0 ? -dy : dy) * 128'(dy < 0 ? -dy : dy);
        rem  = 0;
        root = 0;
        for (int i = 33; i >= 0; i--)
        begin
            rem   = (rem << 2) | {126'b0, sum[2*i +: 2]};
            trial = (root << 2) | 128'd1;
            if (rem >= trial)
            begin
                rem  = rem - trial;
                root = (root << 1) | 128'd1;
            end
            else
                root = root << 1;
        end
        rsum = longint'({1'b0, w.radius_a}) + longint'({1'b0, w.radius_b});
        ovl  = rsum - longint'(root);
        shx  = 0;
        shy  = 0;
        r    = '0;
        r.touching = (longint'(root) <= rsum);
        if (root != 0 && ovl > longint'({32'b0, thr}))
        begin
            r.pushed = 1'b1;
            axis_pull(ovl, dx, root, gain, shx, r.push_x);
            axis_pull(ovl, dy, root, gain, shy, r.push_y);
        end
        r.new_pos_x_a = clamp32(longint'(w.pos_x_a) + shx);
        r.new_pos_y_a = clamp32(longint'(w.pos_y_a) + shy);
        r.new_pos_x_b = clamp32(longint'(w.pos_x_b) - shx);
        r.new_pos_y_b = clamp32(longint'(w.pos_y_b) - shy);
        swap_momentum(w.mass_a, w.mass_b, longint'(w.vel_x_a), longint'(w.vel_x_b),
                      r.new_vel_x_a, r.new_vel_x_b);
        swap_momentum(w.mass_a, w.mass_b, longint'(w.vel_y_a), longint'(w.vel_y_b),
                      r.new_vel_y_a, r.new_vel_y_b);
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s: expected %0h, got %0h", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    // Track registers, queue predictions, compare results
    always @(posedge clk or negedge rst_n)
    begin
        res_t e;
        if (!rst_n)
        begin
            thresh_q   = THRESH_RESET;
            gain_q     = GAIN_RESET;
            fail_count = 0;
            collision_q.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_THRESH)
                    thresh_q = cfg_data;
                else
                    gain_q = cfg_data;
            end
            if (in_valid && in_ready)
                collision_q = {collision_q, resolve_pair(in_word, thresh_q, gain_q)};
            if (out_valid && out_ready)
            begin
                if (collision_q.size() == 0)
                begin
                    $error("result word with no prediction waiting");
                    fail_count++;
                end
                else
                begin
                    e = collision_q.pop_front();
                    check_field("new_pos_x_a", e.new_pos_x_a, out_word.new_pos_x_a);
                    check_field("new_pos_y_a", e.new_pos_y_a, out_word.new_pos_y_a);
                    check_field("new_pos_x_b", e.new_pos_x_b, out_word.new_pos_x_b);
                    check_field("new_pos_y_b", e.new_pos_y_b, out_word.new_pos_y_b);
                    check_field("new_vel_x_a", e.new_vel_x_a, out_word.new_vel_x_a);
                    check_field("new_vel_y_a", e.new_vel_y_a, out_word.new_vel_y_a);
                    check_field("new_vel_x_b", e.new_vel_x_b, out_word.new_vel_x_b);
                    check_field("new_vel_y_b", e.new_vel_y_b, out_word.new_vel_y_b);
                    check_field("push_x", e.push_x, out_word.push_x);
                    check_field("push_y", e.push_y, out_word.push_y);
                    check_field("pushed", 32'(e.pushed), 32'(out_word.pushed));
                    check_field("touching", 32'(e.touching), 32'(out_word.touching));
                end
            end
        end
        pending = collision_q.size();
    end

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 100ps
// Top of the circle pair elastic collision testbench: clock, reset, stimulus,
// register writes and verdict. Depends on cpec_pkg, cpec_checker and the unit.
module tb;
    import cpec_pkg::*;

    localparam int LATENCY   = 74;
    localparam int MAX_CYCLE = 400000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    in_t         pair_w = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    res_t        res_w;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [0:0]  cfg_index = REG_THRESH;
    logic [31:0] cfg_data = '0;
    int          fail_count;
    int          pending;
    bit          quiet = 0;
    bit          hold_out = 0;
    int          cycle = 0;

    always #10 clk = ~clk;

    circle_pair_elastic_collision_unit u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .mass_a(pair_w.mass_a), .mass_b(pair_w.mass_b),
        .radius_a(pair_w.radius_a), .radius_b(pair_w.radius_b),
        .pos_x_a(pair_w.pos_x_a), .pos_y_a(pair_w.pos_y_a),
        .pos_x_b(pair_w.pos_x_b), .pos_y_b(pair_w.pos_y_b),
        .vel_x_a(pair_w.vel_x_a), .vel_y_a(pair_w.vel_y_a),
        .vel_x_b(pair_w.vel_x_b), .vel_y_b(pair_w.vel_y_b),
        .out_valid(out_valid), .out_ready(out_ready),
        .new_pos_x_a(res_w.new_pos_x_a), .new_pos_y_a(res_w.new_pos_y_a),
        .new_pos_x_b(res_w.new_pos_x_b), .new_pos_y_b(res_w.new_pos_y_b),
        .new_vel_x_a(res_w.new_vel_x_a), .new_vel_y_a(res_w.new_vel_y_a),
        .new_vel_x_b(res_w.new_vel_x_b), .new_vel_y_b(res_w.new_vel_y_b),
        .push_x(res_w.push_x), .push_y(res_w.push_y),
        .pushed(res_w.pushed), .touching(res_w.touching),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    cpec_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_word(pair_w),
        .out_valid(out_valid), .out_ready(out_ready), .out_word(res_w),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending(pending)
    );

    // Hold off the receiver in bursts; one long hold when asked
    initial
    begin
        bit burst_mode;
        forever
        begin
            @(posedge clk);
            if (hold_out)
            begin
                out_ready <= 1'b0;
                repeat (400) @(posedge clk);
                hold_out = 0;
            end
            burst_mode = !quiet && ($urandom_range(0, 2) != 0);
            if (burst_mode && $urandom_range(0, 3) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge clk);
            end
            out_ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge clk);
        end
    end

    // Give up at the cycle limit
    always @(posedge clk)
    begin
        cycle++;
        if (cycle >= MAX_CYCLE)
        begin
            $display("circle_pair_elastic_collision_unit verification failed");
            $finish;
        end
    end

    // Offer one word and wait for it to be taken
    task automatic send_pair(input in_t w, input bit gaps);
        if (gaps && !quiet && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        in_valid <= 1'b1;
        pair_w   <= w;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (LATENCY + 6) @(posedge clk);
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [31:0] rnd_mass();
        logic [31:0] m;
        case ($urandom_range(0, 9))
            0:       m = 32'd0;
            1:       m = 32'hFFFF_FFFF;
            2, 3:    m = $urandom();
            default: m = $urandom_range(1, 32'h0100_0000);
        endcase
        return m;
    endfunction

    function automatic logic [31:0] rnd_vel();
        logic [31:0] v;
        case ($urandom_range(0, 5))
            0:       v = 32'h8000_0000;
            1:       v = 32'h7FFF_FFFF;
            2, 3:    v = $urandom();
            default: v = 32'($signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000);
        endcase
        return v;
    endfunction

    // Mostly nearby pairs so that contact and pushes are frequent
    function automatic in_t rnd_pair();
        in_t w;
        int  span;
        w.mass_a  = rnd_mass();
        w.mass_b  = ($urandom_range(0, 15) == 0) ? 32'd0 : rnd_mass();
        w.vel_x_a = rnd_vel();
        w.vel_y_a = rnd_vel();
        w.vel_x_b = rnd_vel();
        w.vel_y_b = rnd_vel();
        case ($urandom_range(0, 9))
            0, 1:
            begin
                w.radius_a = 31'($urandom());
                w.radius_b = 31'($urandom());
                w.pos_x_a  = $urandom();
                w.pos_y_a  = $urandom();
                w.pos_x_b  = $urandom();
                w.pos_y_b  = $urandom();
            end
            default:
            begin
                span       = 1 << $urandom_range(4, 28);
                w.radius_a = 31'($urandom_range(0, span));
                w.radius_b = 31'($urandom_range(0, span));
                w.pos_x_a  = $urandom();
                w.pos_y_a  = $urandom();
                w.pos_x_b  = w.pos_x_a + 32'($signed($urandom_range(0, 2 * span)) - span);
                w.pos_y_b  = w.pos_y_a + 32'($signed($urandom_range(0, 2 * span)) - span);
                if ($urandom_range(0, 19) == 0)
                    w.pos_y_b = w.pos_y_a;
            end
        endcase
        return w;
    endfunction

    task automatic random_run(input int n, input bit gaps);
        for (int i = 0; i < n; i++)
        begin
            if (i == n / 2 && n >= 200 && !quiet)
            begin
                hold_out = 1;
                send_pair(rnd_pair(), 0);
            end
            else
                send_pair(rnd_pair(), gaps && ((i / 40) % 3 != 0));
        end
    endtask

    initial
    begin
        in_t w;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed corners at reset register values
        w = '0;
        w.mass_a = 32'h0001_0000;
        w.mass_b = 32'h0001_0000;
        send_pair(w, 0);                         // coincident centres, zero radii and velocities
        w.radius_a = 31'h0001_0000;
        w.radius_b = 31'h0001_0000;
        w.vel_x_a = 32'h0003_0000;
        w.vel_x_b = 32'hFFFD_0000;
        send_pair(w, 0);                         // coincident centres with radii
        w.mass_a = 32'd0;
        w.mass_b = 32'd0;
        send_pair(w, 0);                         // zero total mass
        w.mass_b = 32'hFFFF_FFFF;
        w.pos_x_a = 32'h0000_8000;
        send_pair(w, 0);                         // one zero mass, deep overlap
        w.mass_a = 32'hFFFF_FFFF;
        w.vel_x_a = 32'h8000_0000;
        w.vel_x_b = 32'h7FFF_FFFF;
        w.vel_y_a = 32'h7FFF_FFFF;
        w.vel_y_b = 32'h8000_0000;
        send_pair(w, 0);                         // extreme velocities and masses
        w.radius_a = 31'h7FFF_FFFF;
        w.radius_b = 31'h7FFF_FFFF;
        w.pos_x_a = 32'h7FFF_FFFF;
        w.pos_x_b = 32'h8000_0000;
        w.pos_y_a = 32'h8000_0000;
        w.pos_y_b = 32'h7FFF_FFFF;
        send_pair(w, 0);                         // widest offsets, largest radii
        w.radius_a = 31'd0;
        w.radius_b = 31'd0;
        send_pair(w, 0);                         // far apart, zero radii
        w.pos_y_a = 32'h0000_0000;
        w.pos_y_b = 32'h0000_0000;
        w.pos_x_a = 32'h0001_0000;
        w.pos_x_b = 32'h0000_0000;
        w.radius_a = 31'h0000_8000;
        w.radius_b = 31'h0000_8000;
        send_pair(w, 0);                         // exactly touching
        w.radius_a = 31'h0000_999A;
        send_pair(w, 0);                         // overlap at threshold
        w.radius_a = 31'h0000_999B;
        send_pair(w, 0);                         // overlap just over threshold
        w.pos_x_a = 32'h7FFF_FFF0;
        w.pos_x_b = 32'h7FFF_FF00;
        w.radius_a = 31'h7FFF_FFFF;
        send_pair(w, 0);                         // shift saturates position
        for (int i = 0; i < 10; i++)
            send_pair(rnd_pair(), 1);
        drain();

        // Zero threshold and gain
        write_reg(REG_THRESH, 32'd0);
        write_reg(REG_GAIN, 32'd0);
        random_run(200, 1);
        drain();

        // Both registers at their maximum
        write_reg(REG_THRESH, 32'hFFFF_FFFF);
        write_reg(REG_GAIN, 32'hFFFF_FFFF);
        random_run(150, 1);
        drain();

        // Random register values, long receiver hold in the middle
        write_reg(REG_THRESH, $urandom_range(0, 32'h0004_0000));
        write_reg(REG_GAIN, $urandom());
        random_run(300, 1);
        drain();

        // Unit gain, small threshold, no idling
        write_reg(REG_THRESH, 32'd1);
        write_reg(REG_GAIN, 32'h0001_0000);
        quiet = 1;
        random_run(200, 0);
        drain();

        if (fail_count == 0)
            $display("circle_pair_elastic_collision_unit verification clean");
        else
            $display("circle_pair_elastic_collision_unit verification failed");
        $finish;
    end

endmodule

>>> files.f
src/cpec_pkg.sv
src/cpec_core.sv
src/circle_pair_elastic_collision_unit.sv
src/cpec_checker.sv
tb/sv/cpec_checker.sv
tb/sv/tb.sv
